@@ rtl/core/rcw_pkg.sv @@
// Package for the RIFF chunk walker: event and status codes, phases, constants.
// No dependencies.
package rcw_pkg;

  localparam int unsigned MaxLevels = 16;
  localparam int unsigned LvlW = $clog2(MaxLevels);
  localparam int unsigned DepW = $clog2(MaxLevels + 1);

  localparam logic [31:0] IdRiff = 32'h4646_4952;
  localparam logic [31:0] IdList = 32'h5453_494C;
  localparam logic [31:0] IdBw64 = 32'h3436_5742;

  typedef enum logic [2:0] {
    EV_HEADER = 3'd0,
    EV_LIST   = 3'd1,
    EV_LEND   = 3'd2,
    EV_DONE   = 3'd3,
    EV_ERROR  = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EOL    = 3'd1,
    ST_EXCESS = 3'd2,
    ST_BADID  = 3'd3,
    ST_XLIST  = 3'd4,
    ST_XFILE  = 3'd5,
    ST_FULL   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    PH_FHDR = 3'd0,
    PH_CHDR = 3'd1,
    PH_TYPE = 3'd2,
    PH_SKIP = 3'd3,
    PH_DONE = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTE,
    S_BOUND,
    S_POP,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    REG_FILE_SIZE   = 2'd0,
    REG_ACCEPT_BW64 = 2'd1
  } reg_e;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] chunk_id;
    logic [31:0] chunk_size;
    logic [31:0] chunk_start;
    logic [31:0] list_type;
    logic [4:0]  nesting_level;
    logic [2:0]  status;
    logic        last_of_run;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // take the accepted byte
    logic step;      // byte step: advance header phases
    logic bound;     // evaluate boundary at the current position
    logic pop;       // apply the pop whose stack entry is now read
    logic eos_chk;   // final end-of-stream check
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;      // a result is produced this cycle
    logic go_bound;  // byte step asks for a boundary evaluation
    logic need_pop;  // boundary asks for a pop
    logic eos;       // byte carried the end flag
  } stat_t;

  function automatic logic printable(input logic [31:0] w);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (w[8*i +: 8] < 8'h20 || w[8*i +: 8] > 8'h7e) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

@@ rtl/core/rcw_if.sv @@
// Valid/ready channel interfaces for the RIFF chunk walker.
// Depends on rcw_pkg.
interface rcw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;
  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

interface rcw_out_if;
  logic             valid;
  logic             ready;
  rcw_pkg::result_t res;
  modport source (output valid, res, input ready);
  modport sink (input valid, res, output ready);
endinterface

interface rcw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/rcw_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module rcw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/core/rcw_ctrl.sv @@
// Controller of the RIFF chunk walker: sequences byte, boundary and pop steps.
// Depends on rcw_pkg.
module rcw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_busy_i,
  input  rcw_pkg::stat_t stat_i,
  output rcw_pkg::cmd_t  cmd_o
);
  import rcw_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_BYTE;
      end
      S_BYTE: begin
        if (!out_busy_i) begin
          if (stat_i.go_bound) state_d = S_BOUND;
          else state_d = S_EMIT;
        end
      end
      S_BOUND: begin
        if (!out_busy_i) begin
          if (stat_i.need_pop) state_d = S_POP;
          else state_d = S_EMIT;
        end
      end
      S_POP: begin
        if (!out_busy_i) state_d = S_BOUND;
      end
      S_EMIT: begin
        if (!out_busy_i && !stat_i.emit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_BYTE:  cmd_o.step = !out_busy_i;
      S_BOUND: cmd_o.bound = !out_busy_i;
      S_POP:   cmd_o.pop = !out_busy_i;
      S_EMIT:  cmd_o.eos_chk = !out_busy_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

@@ rtl/core/rcw_dp.sv @@
// Datapath of the RIFF chunk walker: positions, header shifter, level stack
// and result staging. Depends on rcw_pkg and rcw_ram.
module rcw_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rcw_pkg::cmd_t    cmd_i,
  output rcw_pkg::stat_t   stat_o,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_stream_i,
  input  logic [31:0]      file_size_i,
  input  logic             accept_bw64_i,
  output logic             out_busy_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rcw_pkg::result_t out_res_o
);
  import rcw_pkg::*;

  logic [32:0]        pos_q, pos_d;
  phase_e             phase_q, phase_d;
  logic [63:0]        shift_q, shift_d;
  logic [32:0]        skip_q, skip_d;
  logic [DepW-1:0]    depth_q, depth_d;
  logic [32:0]        lend_q, lend_d;
  logic               halted_q, halted_d;
  logic [MaxLevels-1:0] pad_q, pad_d;
  logic [31:0]        pid_q, pid_d, psize_q, psize_d;
  logic [32:0]        pstart_q, pstart_d;
  logic               eos_q, eos_d;
  logic               hold_q, hold_d;
  result_t            hres_q, hres_d;
  logic               ovalid_q, ovalid_d;
  result_t            ores_q, ores_d;
  logic               go_q, go_d, popreq_d;

  logic               we;
  logic [LvlW-1:0]    waddr, raddr;
  logic [32:0]        rdata;

  logic               emit;
  result_t            eres;

  assign out_valid_o = ovalid_q;
  assign out_res_o   = ores_q;
  assign out_busy_o  = ovalid_q && !out_ready_i;

  rcw_ram #(.Width(33), .Depth(MaxLevels)) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (lend_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign raddr = LvlW'(depth_q - DepW'(1));

  always_comb begin
    logic [31:0] id, sz, ty;
    logic [32:0] start, tot;
    logic [33:0] cend;
    pos_d = pos_q; phase_d = phase_q; shift_d = shift_q; skip_d = skip_q;
    depth_d = depth_q; lend_d = lend_q; halted_d = halted_q; pad_d = pad_q;
    pid_d = pid_q; psize_d = psize_q; pstart_d = pstart_q;
    eos_d = eos_q; go_d = go_q; popreq_d = 1'b0;
    we = 1'b0; waddr = depth_q[LvlW-1:0];
    emit = 1'b0; eres = '0;
    id = shift_q[31:0]; sz = shift_q[63:32]; ty = shift_q[63:32];
    start = '0; cend = '0; tot = '0;

    if (cmd_i.load) begin
      eos_d = end_of_stream_i;
      if (!halted_q) begin
        shift_d = {data_byte_i, shift_q[63:8]};
        pos_d = pos_q + 33'd1;
      end
      go_d = 1'b0;
    end

    if (cmd_i.step && !halted_q) begin
      case (phase_q)
        PH_FHDR: begin
          if (pos_q == 33'd4) begin
            pid_d = shift_q[63:32];
            if (!(shift_q[63:32] == IdRiff ||
                  (accept_bw64_i && shift_q[63:32] == IdBw64))) begin
              emit = 1'b1; halted_d = 1'b1;
              eres.event_kind = EV_ERROR; eres.chunk_id = shift_q[63:32];
              eres.status = ST_BADID;
            end
          end else if (pos_q >= 33'd12) begin
            tot = {1'b0, id} + 33'd8;
            if (file_size_i != 0 && {1'b0, file_size_i} != tot) begin
              emit = 1'b1; halted_d = 1'b1;
              eres.event_kind = EV_ERROR; eres.chunk_id = pid_q; eres.chunk_size = id;
              eres.status = ({1'b0, file_size_i} > tot) ? ST_EXCESS : ST_XFILE;
            end else begin
              lend_d = tot; depth_d = '0;
              emit = 1'b1;
              eres.event_kind = EV_LIST; eres.chunk_id = pid_q; eres.chunk_size = id;
              eres.list_type = ty;
              go_d = 1'b1;
            end
          end
        end
        PH_CHDR: begin
          skip_d = (skip_q != 0) ? skip_q - 33'd1 : skip_q;
          if (skip_d == 0) begin
            start = pos_q - 33'd8;
            cend = {1'b0, start} + 34'd8 + {2'b0, sz} + {33'd0, sz[0]};
            eres.chunk_id = id; eres.chunk_size = sz; eres.chunk_start = start[31:0];
            eres.nesting_level = 5'(depth_q);
            emit = 1'b1;
            if (!printable(id)) begin
              halted_d = 1'b1; eres.event_kind = EV_ERROR; eres.status = ST_BADID;
            end else if (cend > {1'b0, lend_q}) begin
              halted_d = 1'b1; eres.event_kind = EV_ERROR; eres.status = ST_XLIST;
            end else if (file_size_i != 0 && cend > {2'b0, file_size_i}) begin
              halted_d = 1'b1; eres.event_kind = EV_ERROR; eres.status = ST_XFILE;
            end else begin
              eres.event_kind = EV_HEADER;
              if ((id == IdList || id == IdRiff || (accept_bw64_i && id == IdBw64))
                  && sz >= 32'd4) begin
                pid_d = id; psize_d = sz; pstart_d = start;
                skip_d = 33'd4; phase_d = PH_TYPE;
              end else begin
                skip_d = {1'b0, sz} + {32'd0, sz[0]};
                if (skip_d == 0) go_d = 1'b1;
                else phase_d = PH_SKIP;
              end
            end
          end
        end
        PH_TYPE: begin
          skip_d = (skip_q != 0) ? skip_q - 33'd1 : skip_q;
          if (skip_d == 0) begin
            emit = 1'b1;
            eres.chunk_id = pid_q; eres.chunk_size = psize_q;
            eres.chunk_start = pstart_q[31:0];
            if (!printable(ty)) begin
              halted_d = 1'b1; eres.event_kind = EV_ERROR; eres.status = ST_BADID;
              eres.nesting_level = 5'(depth_q);
            end else if (depth_q >= DepW'(MaxLevels)) begin
              halted_d = 1'b1; eres.event_kind = EV_ERROR; eres.status = ST_FULL;
              eres.nesting_level = 5'(depth_q);
            end else begin
              we = 1'b1;
              pad_d[depth_q[LvlW-1:0]] = psize_q[0];
              depth_d = depth_q + DepW'(1);
              lend_d = pstart_q + 33'd8 + {1'b0, psize_q};
              eres.event_kind = EV_LIST; eres.list_type = ty;
              eres.nesting_level = 5'(depth_d);
              go_d = 1'b1;
            end
          end
        end
        PH_SKIP: begin
          skip_d = (skip_q != 0) ? skip_q - 33'd1 : skip_q;
          if (skip_d == 0) go_d = 1'b1;
        end
        default: begin
          emit = 1'b1; halted_d = 1'b1;
          eres.event_kind = EV_ERROR; eres.status = ST_EXCESS;
          eres.nesting_level = 5'(depth_q);
        end
      endcase
    end

    if (cmd_i.bound) begin
      go_d = 1'b0;
    end

    if (cmd_i.bound && go_q && !halted_q) begin
      if (lend_q <= pos_q) begin
        if (depth_q == 0) begin
          emit = 1'b1; eres.event_kind = EV_DONE; phase_d = PH_DONE;
        end else begin
          popreq_d = 1'b1;
        end
      end else if (lend_q < pos_q + 33'd8) begin
        emit = 1'b1; halted_d = 1'b1;
        eres.event_kind = EV_ERROR; eres.status = ST_EXCESS;
        eres.nesting_level = 5'(depth_q);
      end else begin
        skip_d = 33'd8; phase_d = PH_CHDR;
      end
    end

    if (cmd_i.pop) begin
      depth_d = depth_q - DepW'(1);
      lend_d = rdata;
      emit = 1'b1;
      eres.event_kind = EV_LEND; eres.status = ST_EOL;
      eres.nesting_level = 5'(depth_d);
      if (pad_q[raddr]) begin
        skip_d = 33'd1; phase_d = PH_SKIP;
      end else begin
        go_d = 1'b1;
      end
    end

    if (cmd_i.eos_chk && eos_q && !halted_q && phase_q != PH_DONE) begin
      emit = 1'b1; halted_d = 1'b1;
      eres.event_kind = EV_ERROR; eres.status = ST_XFILE;
      eres.nesting_level = 5'(depth_q);
    end
  end

  // A result is held one step so that the last one of a byte can be marked.
  always_comb begin
    hold_d = hold_q; hres_d = hres_q;
    ovalid_d = ovalid_q && !out_ready_i;
    ores_d = ores_q;
    if (emit) begin
      hold_d = 1'b1; hres_d = eres;
      if (hold_q) begin
        ovalid_d = 1'b1; ores_d = hres_q; ores_d.last_of_run = 1'b0;
      end
    end else if (cmd_i.eos_chk && hold_q) begin
      hold_d = 1'b0;
      ovalid_d = 1'b1; ores_d = hres_q; ores_d.last_of_run = 1'b1;
    end
  end

  assign stat_o.emit = emit;
  assign stat_o.go_bound = go_d;
  assign stat_o.need_pop = popreq_d;
  assign stat_o.eos = eos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; phase_q <= PH_FHDR; shift_q <= '0; skip_q <= '0;
      depth_q <= '0; lend_q <= '0; halted_q <= 1'b0; pad_q <= '0;
      eos_q <= 1'b0; hold_q <= 1'b0; ovalid_q <= 1'b0;
      go_q <= 1'b0;
    end else begin
      pos_q <= pos_d; phase_q <= phase_d; shift_q <= shift_d; skip_q <= skip_d;
      depth_q <= depth_d; lend_q <= lend_d; halted_q <= halted_d; pad_q <= pad_d;
      eos_q <= eos_d; hold_q <= hold_d; ovalid_q <= ovalid_d;
      go_q <= go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pid_q <= pid_d; psize_q <= psize_d; pstart_q <= pstart_d;
    hres_q <= hres_d; ores_q <= ores_d;
  end

`ifndef NO_ASSERTIONS
  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepW'(MaxLevels)) else $error("level stack depth out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> depth_q != 0) else $error("pop from empty level stack");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt released without reset");
`endif
endmodule

@@ rtl/core/riff_chunk_walker.sv @@
// Top level of the RIFF chunk walker: configuration registers, controller and
// datapath. Depends on rcw_pkg, rcw_if, rcw_ctrl and rcw_dp.
//
//   channel  direction  transfer
//   in_if    sink       one file byte with end flag
//   out_if   source     one event result
//   cfg_if   sink       one register write (index, data)
//
// A byte passes through accept, byte step and end check, plus a boundary step
// when it reaches a boundary and a pop and boundary again for every level closed
// on that byte; an end-of-stream error adds another end check for its flush.
// Results leave through an output register; a stalled output holds the
// controller. Reset clears the parser state; the level stack needs no clearing.
module riff_chunk_walker (
  input logic      clk_i,
  input logic      rst_ni,
  rcw_in_if.sink   in_if,
  rcw_out_if.source out_if,
  rcw_cfg_if.sink  cfg_if
);
  import rcw_pkg::*;

  logic [31:0] file_size_q;
  logic        accept_bw64_q;
  cmd_t        cmd;
  stat_t       stat;
  logic        busy;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
      accept_bw64_q <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_FILE_SIZE:   file_size_q <= cfg_if.data;
        REG_ACCEPT_BW64: accept_bw64_q <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  rcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_busy_i (busy),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rcw_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .data_byte_i     (in_if.data_byte),
    .end_of_stream_i (in_if.end_of_stream),
    .file_size_i     (file_size_q),
    .accept_bw64_i   (accept_bw64_q),
    .out_busy_o      (busy),
    .out_valid_o     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .out_res_o       (out_if.res)
  );
endmodule
